// ===== rtl/rgb_led_overlay_multiplexer_core_defines.svh =====
// assertion macros shared by the checker
`ifndef RGB_LED_OVERLAY_MULTIPLEXER_CORE_DEFINES_SVH
`define RGB_LED_OVERLAY_MULTIPLEXER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RLOM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlom: same-cycle check failed");

// consequent checked from the following cycle on
`define RLOM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlom: next-cycle check failed");

`endif

// ===== rtl/rlom_pkg.sv =====
`timescale 1ns / 1ps

package rlom_pkg;

   localparam int OVERLAY_SLOTS = 4;
   localparam int SLOT_BITS     = (OVERLAY_SLOTS > 1) ? $clog2(OVERLAY_SLOTS) : 1;
   localparam int CNT_BITS      = $clog2(OVERLAY_SLOTS + 1);
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [15:0] FLASH_MIN_RESET  = 16'd50;
   localparam logic [15:0] ROTATE_RESET     = 16'd100;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_SHOW  = 2'd1,
      MODE_FLASH = 2'd2,
      MODE_OFF   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_OUTPUT_ENABLE   = 2'd0,
      REG_FLASH_MIN       = 2'd1,
      REG_ROTATE_INTERVAL = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] flash_min;
      logic [15:0] rotate_interval;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic expire_step;
      logic rot_step;
      logic flash_step;
      logic flash_write;
      logic live_step;
      logic select_step;
      logic sched;
      logic paint;
      logic finish;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     pass_due;
      logic     colour_off;
      logic     last_slot;
      logic     out_free;
   } stat_type;

endpackage

// ===== rtl/rlom_csr.sv =====
`timescale 1ns / 1ps

module rlom_csr import rlom_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic        enable_ff, enable_in;
   logic [15:0] flash_min_ff, flash_min_in;
   logic [15:0] rotate_ff, rotate_in;
   logic        wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      enable_in    = enable_ff;
      flash_min_in = flash_min_ff;
      rotate_in    = rotate_ff;
      if (wr_en) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_OUTPUT_ENABLE:   enable_in    = csr_pwdata[0];
            REG_FLASH_MIN:       flash_min_in = csr_pwdata[15:0];
            REG_ROTATE_INTERVAL: rotate_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_OUTPUT_ENABLE:   csr_prdata = {{(CSR_DATA_BITS-1){1'b0}}, enable_ff};
         REG_FLASH_MIN:       csr_prdata = {{(CSR_DATA_BITS-16){1'b0}}, flash_min_ff};
         REG_ROTATE_INTERVAL: csr_prdata = {{(CSR_DATA_BITS-16){1'b0}}, rotate_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         flash_min_ff <= FLASH_MIN_RESET;
         rotate_ff    <= ROTATE_RESET;
      end else begin
         enable_ff    <= enable_in;
         flash_min_ff <= flash_min_in;
         rotate_ff    <= rotate_in;
      end
   end

   assign cfg.enable          = enable_ff;
   assign cfg.flash_min       = flash_min_ff;
   assign cfg.rotate_interval = rotate_ff;

endmodule

// ===== rtl/rlom_ctrl.sv =====
`timescale 1ns / 1ps

module rlom_ctrl import rlom_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [10:0] {
      ST_IDLE       = 11'b000_0000_0001,
      ST_DECODE     = 11'b000_0000_0010,
      ST_EXPIRE     = 11'b000_0000_0100,
      ST_ROTATE     = 11'b000_0000_1000,
      ST_FLASH_SCAN = 11'b000_0001_0000,
      ST_FLASH_WR   = 11'b000_0010_0000,
      ST_LIVE       = 11'b000_0100_0000,
      ST_SELECT     = 11'b000_1000_0000,
      ST_SCHED      = 11'b001_0000_0000,
      ST_PAINT      = 11'b010_0000_0000,
      ST_FINISH     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.mode)
               MODE_TICK:  state_in = stat.pass_due ? ST_EXPIRE : ST_FINISH;
               MODE_SHOW:  state_in = ST_LIVE;
               MODE_OFF:   state_in = ST_LIVE;
               MODE_FLASH: state_in = stat.colour_off ? ST_FINISH : ST_FLASH_SCAN;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_EXPIRE: begin
            cmd.expire_step = 1'b1;
            if (stat.last_slot) state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rot_step = 1'b1;
            state_in     = ST_LIVE;
         end
         ST_FLASH_SCAN: begin
            cmd.flash_step = 1'b1;
            if (stat.last_slot) state_in = ST_FLASH_WR;
         end
         ST_FLASH_WR: begin
            cmd.flash_write = 1'b1;
            state_in        = ST_LIVE;
         end
         ST_LIVE: begin
            cmd.live_step = 1'b1;
            if (stat.last_slot) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.select_step = 1'b1;
            if (stat.last_slot) state_in = ST_SCHED;
         end
         ST_SCHED: begin
            cmd.sched = 1'b1;
            state_in  = ST_PAINT;
         end
         ST_PAINT: begin
            cmd.paint = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/rlom_datapath.sv =====
`timescale 1ns / 1ps

module rlom_datapath import rlom_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  cfg_type     cfg,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_brightness,
   input  logic [15:0] req_duration_ms,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [7:0]  rsp_led_red,
   output logic [7:0]  rsp_led_green,
   output logic [7:0]  rsp_led_blue,
   output logic        rsp_updated
);

   // x / 255 for x up to 255*255
   function automatic logic [7:0] div_full_scale(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   // request latch
   mode_type    mode_ff, mode_in;
   logic [31:0] colour_ff, colour_in;
   logic [15:0] dur_ff, dur_in;
   logic        pass_ff, pass_in;

   // block state
   logic [31:0] now_ff, now_in;
   logic [31:0] slot_colour_ff [OVERLAY_SLOTS];
   logic [31:0] slot_colour_in [OVERLAY_SLOTS];
   logic [31:0] slot_deadline_ff [OVERLAY_SLOTS];
   logic [31:0] slot_deadline_in [OVERLAY_SLOTS];
   logic [31:0] steady_ff, steady_in;
   logic [31:0] rot_index_ff, rot_index_in;
   logic [SLOT_BITS-1:0] rot_mod_ff [OVERLAY_SLOTS];
   logic [SLOT_BITS-1:0] rot_mod_in [OVERLAY_SLOTS];
   logic        timer_run_ff, timer_run_in;
   logic [15:0] timer_cnt_ff, timer_cnt_in;
   logic [23:0] led_ff, led_in;
   logic        painted_ff, painted_in;

   // scan state
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0]  active_ff, active_in;
   logic [CNT_BITS-1:0]  live_cnt_ff, live_cnt_in;
   logic [OVERLAY_SLOTS-1:0] live_mask_ff, live_mask_in;
   logic [CNT_BITS-1:0]  hit_ff, hit_in;
   logic [31:0]          sel_colour_ff, sel_colour_in;
   logic                 match_found_ff, match_found_in;
   logic [SLOT_BITS-1:0] match_idx_ff, match_idx_in;
   logic [31:0]          match_dl_ff, match_dl_in;
   logic                 free_found_ff, free_found_in;
   logic [SLOT_BITS-1:0] free_idx_ff, free_idx_in;
   logic [SLOT_BITS-1:0] best_idx_ff, best_idx_in;
   logic [31:0]          best_dl_ff, best_dl_in;
   logic [15:0]          prod_r_ff, prod_r_in;
   logic [15:0]          prod_g_ff, prod_g_in;
   logic [15:0]          prod_b_ff, prod_b_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_led_ff, rsp_led_in;
   logic        rsp_upd_ff, rsp_upd_in;

   // helpers
   logic [31:0] req_colour;
   logic [31:0] cur_colour, cur_dl;
   logic        cur_on, cur_live, cur_free, cur_match;
   logic        first, last;
   logic [15:0] period, cnt_next, dur_eff;
   logic [CNT_BITS-1:0]  act_prev, live_prev, hit_prev, target;
   logic [SLOT_BITS-1:0] live_sel, pick_idx;
   logic [31:0] base, paint_c;
   logic        mf_prev, ff_prev;

   assign req_colour = {req_brightness, req_red, req_green, req_blue};
   assign cur_colour = slot_colour_ff[idx_ff];
   assign cur_dl     = slot_deadline_ff[idx_ff];
   assign cur_on     = |cur_colour[23:0];
   assign cur_live   = cur_on && (cur_dl > now_ff);
   assign cur_free   = !cur_on || (cur_dl <= now_ff);
   assign cur_match  = (cur_colour == colour_ff) && (cur_dl > now_ff);
   assign first      = (idx_ff == '0);
   assign last       = (idx_ff == SLOT_BITS'(OVERLAY_SLOTS - 1));
   assign period     = (cfg.rotate_interval == '0) ? 16'd1 : cfg.rotate_interval;
   assign cnt_next   = timer_cnt_ff + 16'd1;
   assign dur_eff    = (dur_ff < cfg.flash_min) ? cfg.flash_min : dur_ff;
   assign act_prev   = first ? '0 : active_ff;
   assign live_prev  = first ? '0 : live_cnt_ff;
   assign hit_prev   = first ? '0 : hit_ff;
   assign mf_prev    = first ? 1'b0 : match_found_ff;
   assign ff_prev    = first ? 1'b0 : free_found_ff;
   assign live_sel   = SLOT_BITS'(live_cnt_ff - CNT_BITS'(1));
   assign target     = CNT_BITS'(rot_mod_ff[live_sel]);
   assign pick_idx   = match_found_ff ? match_idx_ff :
                       free_found_ff  ? free_idx_ff  : best_idx_ff;
   assign base       = match_found_ff ? match_dl_ff : now_ff;
   assign paint_c    = (live_cnt_ff == '0) ? steady_ff : sel_colour_ff;

   always_comb begin
      mode_in        = mode_ff;
      colour_in      = colour_ff;
      dur_in         = dur_ff;
      pass_in        = pass_ff;
      now_in         = now_ff;
      slot_colour_in   = slot_colour_ff;
      slot_deadline_in = slot_deadline_ff;
      steady_in      = steady_ff;
      rot_index_in   = rot_index_ff;
      rot_mod_in     = rot_mod_ff;
      timer_run_in   = timer_run_ff;
      timer_cnt_in   = timer_cnt_ff;
      led_in         = led_ff;
      painted_in     = painted_ff;
      idx_in         = idx_ff;
      active_in      = active_ff;
      live_cnt_in    = live_cnt_ff;
      live_mask_in   = live_mask_ff;
      hit_in         = hit_ff;
      sel_colour_in  = sel_colour_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_dl_in    = match_dl_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_dl_in     = best_dl_ff;
      prod_r_in      = prod_r_ff;
      prod_g_in      = prod_g_ff;
      prod_b_in      = prod_b_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_led_in     = rsp_led_ff;
      rsp_upd_in     = rsp_upd_ff;

      if (cmd.accept) begin
         mode_in    = mode_type'(req_mode);
         colour_in  = req_colour;
         dur_in     = req_duration_ms;
         pass_in    = 1'b0;
         painted_in = 1'b0;
         idx_in     = '0;
         case (mode_type'(req_mode))
            MODE_TICK: begin
               now_in = now_ff + 32'd1;
               if (timer_run_ff) begin
                  if (cnt_next >= period) begin
                     timer_cnt_in = '0;
                     pass_in      = 1'b1;
                  end else begin
                     timer_cnt_in = cnt_next;
                  end
               end
            end
            MODE_SHOW, MODE_OFF: begin
               // off is a steady show of the all-zero colour
               steady_in = (mode_type'(req_mode) == MODE_SHOW) ? req_colour : '0;
               for (int i = 0; i < OVERLAY_SLOTS; i++) begin
                  slot_colour_in[i]   = '0;
                  slot_deadline_in[i] = '0;
                  rot_mod_in[i]       = '0;
               end
               rot_index_in = '0;
            end
            default: ;
         endcase
      end

      if (cmd.expire_step || cmd.flash_step || cmd.live_step || cmd.select_step) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end

      if (cmd.expire_step) begin
         active_in = act_prev;
         if (cur_on && !cur_live) begin
            slot_colour_in[idx_ff]   = '0;
            slot_deadline_in[idx_ff] = '0;
         end else if (cur_on) begin
            active_in = act_prev + 1'b1;
         end
      end

      if (cmd.rot_step && (active_ff > CNT_BITS'(1))) begin
         if (rot_index_ff == '1) begin
            rot_index_in = '0;
            for (int i = 0; i < OVERLAY_SLOTS; i++) rot_mod_in[i] = '0;
         end else begin
            rot_index_in = rot_index_ff + 32'd1;
            // entry i tracks the rotation index modulo i+1
            for (int i = 0; i < OVERLAY_SLOTS; i++) begin
               rot_mod_in[i] = (rot_mod_ff[i] == SLOT_BITS'(i)) ? '0 : rot_mod_ff[i] + 1'b1;
            end
         end
      end

      if (cmd.flash_step) begin
         match_found_in = mf_prev;
         free_found_in  = ff_prev;
         if (!mf_prev && cur_match) begin
            match_found_in = 1'b1;
            match_idx_in   = idx_ff;
            match_dl_in    = cur_dl;
         end
         if (!ff_prev && cur_free) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end
         if (first || (cur_dl < best_dl_ff)) begin
            best_idx_in = idx_ff;
            best_dl_in  = cur_dl;
         end
      end

      if (cmd.flash_write) begin
         slot_colour_in[pick_idx]   = colour_ff;
         slot_deadline_in[pick_idx] = base + {16'd0, dur_eff};
      end

      if (cmd.live_step) begin
         live_mask_in[idx_ff] = cur_live;
         live_cnt_in          = live_prev + CNT_BITS'(cur_live);
      end

      if (cmd.select_step) begin
         hit_in = hit_prev;
         if (live_mask_ff[idx_ff]) begin
            if (hit_prev == target) sel_colour_in = cur_colour;
            hit_in = hit_prev + 1'b1;
         end
      end

      if (cmd.sched) begin
         if (live_cnt_ff == '0) begin
            timer_run_in = 1'b0;
            timer_cnt_in = '0;
         end else if (!timer_run_ff) begin
            timer_run_in = 1'b1;
            timer_cnt_in = '0;
         end
         prod_r_in = 16'(paint_c[23:16]) * 16'(paint_c[31:24]);
         prod_g_in = 16'(paint_c[15:8])  * 16'(paint_c[31:24]);
         prod_b_in = 16'(paint_c[7:0])   * 16'(paint_c[31:24]);
      end

      if (cmd.paint && cfg.enable) begin
         led_in     = {div_full_scale(prod_r_ff), div_full_scale(prod_g_ff),
                       div_full_scale(prod_b_ff)};
         painted_in = 1'b1;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_led_in   = led_ff;
         rsp_upd_in   = painted_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff      <= 1'b0;
         now_ff       <= '0;
         for (int i = 0; i < OVERLAY_SLOTS; i++) begin
            slot_colour_ff[i]   <= '0;
            slot_deadline_ff[i] <= '0;
            rot_mod_ff[i]       <= '0;
         end
         steady_ff    <= '0;
         rot_index_ff <= '0;
         timer_run_ff <= 1'b0;
         timer_cnt_ff <= '0;
         led_ff       <= '0;
         painted_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pass_ff          <= pass_in;
         now_ff           <= now_in;
         slot_colour_ff   <= slot_colour_in;
         slot_deadline_ff <= slot_deadline_in;
         rot_mod_ff       <= rot_mod_in;
         steady_ff        <= steady_in;
         rot_index_ff     <= rot_index_in;
         timer_run_ff     <= timer_run_in;
         timer_cnt_ff     <= timer_cnt_in;
         led_ff           <= led_in;
         painted_ff       <= painted_in;
         idx_ff           <= idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      colour_ff      <= colour_in;
      dur_ff         <= dur_in;
      active_ff      <= active_in;
      live_cnt_ff    <= live_cnt_in;
      live_mask_ff   <= live_mask_in;
      hit_ff         <= hit_in;
      sel_colour_ff  <= sel_colour_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_dl_ff    <= match_dl_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_dl_ff     <= best_dl_in;
      prod_r_ff      <= prod_r_in;
      prod_g_ff      <= prod_g_in;
      prod_b_ff      <= prod_b_in;
      rsp_led_ff     <= rsp_led_in;
      rsp_upd_ff     <= rsp_upd_in;
   end

   assign stat.mode       = mode_ff;
   assign stat.pass_due   = pass_ff;
   assign stat.colour_off = ~|colour_ff[23:0];
   assign stat.last_slot  = last;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_red   = rsp_led_ff[23:16];
   assign rsp_led_green = rsp_led_ff[15:8];
   assign rsp_led_blue  = rsp_led_ff[7:0];
   assign rsp_updated   = rsp_upd_ff;

endmodule

// ===== rtl/rgb_led_overlay_multiplexer_core.sv =====
`timescale 1ns / 1ps
// flow: a tick with no rotation pass, or a flash of an off colour, goes from decode straight
//   to finish; show/off run the live and select scans, a rotation tick or flash one scan and step more
// requests: one in work at a time, the next taken once the last has finished, which waits
//   for a free response register; the single slot scan port is walked one slot per cycle
// reset: synchronous, active high; time, slots, steady colour, timers and led level clear,
//   registers load their defaults; no clearing pass

module rgb_led_overlay_multiplexer_core import rlom_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_mode,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               req_brightness,
   input  logic [15:0]              req_duration_ms,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_led_red,
   output logic [7:0]               rsp_led_green,
   output logic [7:0]               rsp_led_blue,
   output logic                     rsp_updated,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // configuration as seen by the datapath
   cfg_type  cfg;
   // sequencer commands and datapath status
   cmd_type  cmd;
   stat_type stat;

   // output enable, minimum flash length and rotation interval
   rlom_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: one request at a time
   //   tick  -> optional expiry scan and rotation step
   //   flash -> slot pick scan, then one slot write
   //   every repaint -> live scan, select scan, timer schedule + multiply, divide
   // the finish step waits only for the response register to be free, so a new
   // request can be taken while the previous response is still waiting
   rlom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // slot store, clock, rotation counters, scale unit and response register
   rlom_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cfg             (cfg),
      .req_mode        (req_mode),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_brightness  (req_brightness),
      .req_duration_ms (req_duration_ms),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_led_red     (rsp_led_red),
      .rsp_led_green   (rsp_led_green),
      .rsp_led_blue    (rsp_led_blue),
      .rsp_updated     (rsp_updated)
   );

endmodule

// ===== rtl/rlom_checker.sv =====
`timescale 1ns / 1ps
`include "rgb_led_overlay_multiplexer_core_defines.svh"

module rlom_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_led_red,
   input logic [7:0] rsp_led_green,
   input logic [7:0] rsp_led_blue,
   input logic       rsp_updated
);

   // a pending response is held until taken
   `RLOM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // and its payload does not move
   `RLOM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_led_red) && $stable(rsp_led_green) && $stable(rsp_led_blue) && $stable(rsp_updated))

   // one request in work at a time; ready stays low through decode and the step after it
   `RLOM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, (!req_ready ##1 !req_ready))

   // a new response only comes out of a busy sequencer
   `RLOM_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind rgb_led_overlay_multiplexer_core rlom_checker u_rlom_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import rlom_pkg::*; ();

   // overall run limit in clock cycles
   localparam int unsigned RUN_LIMIT = 1_000_000;
   // cycles the receiver holds off during a long stall
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES = 8;

   // one request as the sender sees it, colour packed brightness/red/green/blue
   typedef struct packed {
      mode_type    mode;
      logic [31:0] colour;
      logic [15:0] dur;
   } lamp_req_type;

   // one response: driven led level plus repaint flag
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       updated;
   } lamp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, known from time zero
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [7:0]  req_brightness = '0;
   logic [15:0] req_duration_ms = '0;

   // response channel
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_led_red;
   logic [7:0] rsp_led_green;
   logic [7:0] rsp_led_blue;
   logic       rsp_updated;

   // register port
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   rgb_led_overlay_multiplexer_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // lamp predictor: own copy of registers and overlay state
   // ---------------------------------------------------------------

   // register copies, loaded with their reset defaults
   logic        lamp_enable = 1'b0;
   logic [15:0] flash_floor = FLASH_MIN_RESET;
   logic [15:0] rot_interval = ROTATE_RESET;

   // millisecond clock, overlay slots and steady colour
   logic [31:0] clock_ms = '0;
   logic [31:0] ovl_colour [OVERLAY_SLOTS] = '{default: '0};
   logic [31:0] ovl_deadline [OVERLAY_SLOTS] = '{default: '0};
   logic [31:0] base_colour = '0;
   // rotation timer
   logic [31:0] rot_idx = '0;
   logic        rot_on = 1'b0;
   logic [15:0] rot_count = '0;
   // led output
   logic [23:0] lamp_level = '0;
   logic        lamp_touched = 1'b0;

   // responses predicted but not yet seen
   lamp_rsp_type lamp_expected [$];
   // requests waiting for the driver
   lamp_req_type lamp_cmds [$];

   int unsigned errors = 0;
   int unsigned responses_seen = 0;
   int unsigned cycle_count = 0;
   int          holds_asked = 0;
   int          holds_granted = 0;

   // a colour with red, green and blue all zero is dark, brightness aside
   function automatic bit is_dark(logic [31:0] c);
      return c[23:0] == 24'd0;
   endfunction

   function automatic logic [7:0] scaled(logic [7:0] ch, logic [7:0] br);
      return 8'((16'(ch) * 16'(br)) / 16'd255);
   endfunction

   // repaint is dropped entirely while output is disabled
   function automatic void drive_lamp(logic [31:0] c);
      if (!lamp_enable)
         return;
      if (is_dark(c))
         lamp_level = '0;
      else
         lamp_level = {scaled(c[23:16], c[31:24]), scaled(c[15:8], c[31:24]),
                       scaled(c[7:0], c[31:24])};
      lamp_touched = 1'b1;
   endfunction

   function automatic bit ovl_live(int i);
      return !is_dark(ovl_colour[i]) && ovl_deadline[i] > clock_ms;
   endfunction

   // show the rotation pick among live overlays, else the steady colour
   function automatic void repaint();
      logic [31:0] live_list [OVERLAY_SLOTS];
      int unsigned n;
      n = 0;
      for (int i = 0; i < OVERLAY_SLOTS; i++)
         if (ovl_live(i)) begin
            live_list[n] = ovl_colour[i];
            n++;
         end
      if (n == 0)
         drive_lamp(base_colour);
      else
         drive_lamp(live_list[rot_idx % n]);
   endfunction

   // timer runs only while some overlay is live, count restarts on start
   function automatic void arm_rotation();
      bit any;
      any = 1'b0;
      for (int i = 0; i < OVERLAY_SLOTS; i++)
         if (ovl_live(i))
            any = 1'b1;
      if (!any) begin
         rot_on = 1'b0;
         rot_count = '0;
      end else if (!rot_on) begin
         rot_on = 1'b1;
         rot_count = '0;
      end
   endfunction

   function automatic void wipe_overlays();
      for (int i = 0; i < OVERLAY_SLOTS; i++) begin
         ovl_colour[i] = '0;
         ovl_deadline[i] = '0;
      end
      rot_idx = '0;
   endfunction

   // expire finished overlays, step rotation when two or more remain
   function automatic void rotation_pass();
      int active;
      active = 0;
      for (int i = 0; i < OVERLAY_SLOTS; i++) begin
         if (!is_dark(ovl_colour[i]) && ovl_deadline[i] <= clock_ms) begin
            ovl_colour[i] = '0;
            ovl_deadline[i] = '0;
         end else if (!is_dark(ovl_colour[i])) begin
            active++;
         end
      end
      if (active >= 2)
         rot_idx++;
      repaint();
      arm_rotation();
   endfunction

   // same live colour first, then a free or expired slot, then soonest deadline
   function automatic int claim_slot(logic [31:0] c);
      int best;
      for (int i = 0; i < OVERLAY_SLOTS; i++)
         if (ovl_colour[i] == c && ovl_deadline[i] > clock_ms)
            return i;
      for (int i = 0; i < OVERLAY_SLOTS; i++)
         if (is_dark(ovl_colour[i]) || ovl_deadline[i] <= clock_ms) begin
            ovl_colour[i] = c;
            ovl_deadline[i] = '0;
            return i;
         end
      best = 0;
      for (int i = 0; i < OVERLAY_SLOTS; i++)
         if (ovl_deadline[i] < ovl_deadline[best])
            best = i;
      ovl_colour[best] = c;
      ovl_deadline[best] = '0;
      return best;
   endfunction

   // apply one request to the predictor and return the response it yields
   function automatic lamp_rsp_type lamp_step(lamp_req_type r);
      logic [15:0]  dur;
      logic [15:0]  period;
      logic [31:0]  start;
      int           s;
      lamp_rsp_type o;
      dur = r.dur;
      lamp_touched = 1'b0;
      case (r.mode)
         MODE_TICK: begin
            clock_ms++;
            if (rot_on) begin
               // a zero interval behaves as one tick
               period = (rot_interval == 16'd0) ? 16'd1 : rot_interval;
               rot_count = rot_count + 16'd1;
               if (rot_count >= period) begin
                  rot_count = '0;
                  rotation_pass();
               end
            end
         end
         MODE_SHOW: begin
            base_colour = r.colour;
            wipe_overlays();
            repaint();
            arm_rotation();
         end
         MODE_FLASH: begin
            // flash of a dark colour changes nothing
            if (!is_dark(r.colour)) begin
               if (dur < flash_floor)
                  dur = flash_floor;
               s = claim_slot(r.colour);
               start = (ovl_deadline[s] > clock_ms) ? ovl_deadline[s] : clock_ms;
               ovl_deadline[s] = start + 32'(dur);
               repaint();
               arm_rotation();
            end
         end
         default: begin
            base_colour = '0;
            wipe_overlays();
            drive_lamp('0);
            rot_on = 1'b0;
            rot_count = '0;
         end
      endcase
      o.red = lamp_level[23:16];
      o.green = lamp_level[15:8];
      o.blue = lamp_level[7:0];
      o.updated = lamp_touched;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // per-phase palette so that repeated colours hit slot reuse and eviction
   logic [31:0] palette [6];

   function automatic void push_req(mode_type m, logic [31:0] colour, logic [15:0] dur);
      lamp_req_type r;
      r.mode = m;
      r.colour = colour;
      r.dur = dur;
      lamp_cmds.push_back(r);
   endfunction

   function automatic logic [31:0] pick_colour();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7)
         return palette[$urandom_range(0, 5)];
      else if (roll == 7)
         return {8'($urandom), 24'd0};
      else
         return $urandom;
   endfunction

   function automatic logic [15:0] pick_dur();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return 16'($urandom_range(0, 8));
      else if (roll < 9)
         return 16'($urandom_range(0, 60));
      else
         return 16'($urandom);
   endfunction

   // mostly well-formed runs: optional show, flashes with tick runs between,
   // sometimes an off; the rest is unstructured noise
   task automatic queue_traffic(int target);
      int added;
      int ticks;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               push_req(mode_type'($urandom_range(0, 3)), $urandom, 16'($urandom));
               added++;
            end
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               push_req(MODE_SHOW, pick_colour(), 16'($urandom));
               added++;
            end
            repeat ($urandom_range(1, 5)) begin
               push_req(MODE_FLASH, pick_colour(), pick_dur());
               added++;
               ticks = $urandom_range(0, 12);
               repeat (ticks) push_req(MODE_TICK, $urandom, 16'($urandom));
               added += ticks;
            end
            ticks = $urandom_range(0, 40);
            repeat (ticks) push_req(MODE_TICK, $urandom, 16'($urandom));
            added += ticks;
            if ($urandom_range(0, 7) == 0) begin
               push_req(MODE_OFF, $urandom, 16'($urandom));
               added++;
            end
         end
      end
   endtask

   // setup then access cycle; the register takes the value at the access edge
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_OUTPUT_ENABLE:   lamp_enable = value[0];
         REG_FLASH_MIN:       flash_floor = value[15:0];
         REG_ROTATE_INTERVAL: rot_interval = value[15:0];
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // sender stops until every request is through and every response has come
   task automatic wait_idle();
      do @(negedge clock);
      while (lamp_cmds.size() != 0 || req_valid || lamp_expected.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic report_mismatch(string msg);
      if (errors < 40)
         $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   // ---------------------------------------------------------------
   // request driver: bursts of random length with random gaps
   // ---------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : req_driver
      lamp_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         // slot is free: either idle or the current request goes in at this edge
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (lamp_cmds.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            nxt = lamp_cmds.pop_front();
            req_valid <= 1'b1;
            req_mode <= nxt.mode;
            req_brightness <= nxt.colour[31:24];
            req_red <= nxt.colour[23:16];
            req_green <= nxt.colour[15:8];
            req_blue <= nxt.colour[7:0];
            req_duration_ms <= nxt.dur;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               // a quarter of bursts run straight into the next one
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response receiver: stall styles of random length plus long holds
   // ---------------------------------------------------------------
   int hold_left = 0;
   int style = 0;
   int style_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         style_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_granted < holds_asked) begin
         // long hold so the block backs up and stalls its request side
         holds_granted <= holds_granted + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            style <= $urandom_range(0, 2);
            style_left <= $urandom_range(16, 96);
         end else begin
            style_left <= style_left - 1;
         end
         case (style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // monitor: predicts on each accepted request, checks each response
   // ---------------------------------------------------------------
   always @(posedge clock) begin : lamp_monitor
      lamp_req_type took;
      lamp_rsp_type want;
      if (!reset) begin
         // prediction first, so a same-edge response is ordered deterministically
         if (req_valid && req_ready) begin
            took.mode = mode_type'(req_mode);
            took.colour = {req_brightness, req_red, req_green, req_blue};
            took.dur = req_duration_ms;
            lamp_expected.push_back(lamp_step(took));
         end
         if (rsp_valid && rsp_ready) begin
            if (lamp_expected.size() == 0) begin
               report_mismatch($sformatf("response %0d with none expected", responses_seen));
            end else begin
               want = lamp_expected.pop_front();
               if (rsp_led_red !== want.red)
                  report_mismatch($sformatf("response %0d led_red %0h, expected %0h",
                                            responses_seen, rsp_led_red, want.red));
               if (rsp_led_green !== want.green)
                  report_mismatch($sformatf("response %0d led_green %0h, expected %0h",
                                            responses_seen, rsp_led_green, want.green));
               if (rsp_led_blue !== want.blue)
                  report_mismatch($sformatf("response %0d led_blue %0h, expected %0h",
                                            responses_seen, rsp_led_blue, want.blue));
               if (rsp_updated !== want.updated)
                  report_mismatch($sformatf("response %0d updated %0b, expected %0b",
                                            responses_seen, rsp_updated, want.updated));
            end
            responses_seen++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // phase settings: enable, minimum flash, rotation interval
   logic        enable_set [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
   logic [15:0] floor_set [PHASES] = '{0, 3, 1, 5, 16'hFFFF, 2, 7, 0};
   logic [15:0] interval_set [PHASES] = '{1, 0, 2, 3, 16'hFFFF, 5, 4, 1};

   initial begin : stimulus
      int ph;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // output still disabled after reset: state moves, led does not
      @(negedge clock);
      push_req(MODE_SHOW, 32'hFF_FF_FF_FF, 16'h0000);
      push_req(MODE_FLASH, 32'hFF_FF_00_00, 16'h0000);
      push_req(MODE_TICK, 32'h0, 16'h0);
      wait_idle();

      // zero floor and zero rotation interval: pass runs on every tick
      csr_write(REG_OUTPUT_ENABLE, 32'd1);
      csr_write(REG_FLASH_MIN, 32'd0);
      csr_write(REG_ROTATE_INTERVAL, 32'd0);
      @(negedge clock);
      push_req(MODE_SHOW, 32'h80_FF_00_00, 16'h0000);
      // flash of a dark colour is ignored
      push_req(MODE_FLASH, 32'hFF_00_00_00, 16'd100);
      push_req(MODE_FLASH, 32'hC0_00_FF_00, 16'd2);
      // same colour again extends the live slot
      push_req(MODE_FLASH, 32'hC0_00_FF_00, 16'd3);
      push_req(MODE_FLASH, 32'h40_00_00_FF, 16'd1);
      push_req(MODE_FLASH, 32'hFF_12_34_56, 16'hFFFF);
      push_req(MODE_FLASH, 32'h01_80_80_80, 16'd4);
      // five live colours in four slots: soonest deadline is evicted
      push_req(MODE_FLASH, 32'h7F_FF_FF_00, 16'd5);
      // same rgb, other brightness: a different colour, zero length
      push_req(MODE_FLASH, 32'h10_00_FF_00, 16'd0);
      repeat (6) push_req(MODE_TICK, 32'hFF_FF_FF_FF, 16'hFFFF);
      // brightness zero on a lit colour drives zero but is not dark
      push_req(MODE_SHOW, 32'h00_FF_FF_FF, 16'h0000);
      // short flash expires and the timer stops
      push_req(MODE_FLASH, 32'hFF_01_02_03, 16'd1);
      push_req(MODE_TICK, 32'h0, 16'h0);
      push_req(MODE_TICK, 32'h0, 16'h0);
      push_req(MODE_OFF, 32'hFF_FF_FF_FF, 16'hFFFF);
      // tick with nothing running repaints nothing
      push_req(MODE_TICK, 32'h0, 16'h0);
      push_req(MODE_SHOW, 32'hFF_00_00_00, 16'h0000);
      push_req(MODE_FLASH, 32'hFF_FF_FF_FF, 16'hFFFF);
      push_req(MODE_OFF, 32'h0, 16'h0);
      wait_idle();

      for (ph = 0; ph < PHASES; ph++) begin
         csr_write(REG_OUTPUT_ENABLE, 32'(enable_set[ph]));
         csr_write(REG_FLASH_MIN, 32'(floor_set[ph]));
         csr_write(REG_ROTATE_INTERVAL, 32'(interval_set[ph]));
         @(negedge clock);
         for (int k = 0; k < 5; k++)
            palette[k] = {8'($urandom), 24'($urandom_range(1, 24'hFF_FFFF))};
         palette[5] = {~palette[0][31:24], palette[0][23:0]};
         queue_traffic(90);
         // long receiver hold while the sender keeps offering
         if (ph == 2 || ph == 5)
            holds_asked++;
         // sender pauses mid-phase until all responses are in
         wait_idle();
         queue_traffic(90);
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rlom_pkg.sv
rtl/rlom_csr.sv
rtl/rlom_ctrl.sv
rtl/rlom_datapath.sv
rtl/rgb_led_overlay_multiplexer_core.sv
rtl/rlom_checker.sv
verif/tb_top.sv
